FILE: design/block_average_darkness_grid_top_assert.svh
// ---------------------------------------------------------------------------
// Darkness grid assertion macros
// Shared concurrent assertion forms for the darkness grid checks.
// ---------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_DARKNESS_GRID_TOP_ASSERT_SVH
`define BLOCK_AVERAGE_DARKNESS_GRID_TOP_ASSERT_SVH

// Same-cycle implication.
`define BADG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("darkness grid check failed");

// Next-cycle implication.
`define BADG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("darkness grid check failed");

`endif

FILE: design/badg_pkg.sv
// ---------------------------------------------------------------------------
// Darkness grid package
// Shared constants, register codes and types of the darkness grid block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package badg_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_CELL_DEFAULT  = 16;
   localparam int HEIGHT_LIMIT      = 1024;

   localparam int CHAN_W     = 8;
   localparam int VAL_W      = 10;
   localparam int ROW_W      = 10;
   localparam int DARK_W     = 17;
   localparam int CS_REG_W   = 5;
   localparam int DIM_REG_W  = 11;
   localparam int H_W        = $clog2(HEIGHT_LIMIT + 1);
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CNT_W      = $clog2(DARK_W);

   localparam logic [CS_REG_W-1:0]  CELL_SIZE_RESET    = 5'd8;
   localparam logic [DIM_REG_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [DIM_REG_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;
   localparam logic [DARK_W-1:0]    DARK_FULL          = 17'h10000;

   typedef enum logic [1:0] {
      REG_CELL_SIZE    = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2,
      REG_COLOUR_MODE  = 2'd3
   } badg_reg_type;

   typedef enum logic [2:0] {
      DIV_IDLE = 3'b001,
      DIV_RUN  = 3'b010,
      DIV_DONE = 3'b100
   } badg_div_state_type;

   typedef struct packed {
      logic [ROW_W-1:0] cell_row;
      logic [ROW_W-1:0] cell_col;
      logic             frame_end;
   } badg_tag_type;

   typedef struct packed {
      logic start;
      logic res_ready;
   } badg_div_ctrl_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } badg_div_stat_type;

endpackage

FILE: design/badg_req_if.sv
// ---------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one pixel of three channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface badg_req_if;
   logic                        valid;
   logic                        ready;
   logic [badg_pkg::CHAN_W-1:0] chan_a;
   logic [badg_pkg::CHAN_W-1:0] chan_b;
   logic [badg_pkg::CHAN_W-1:0] chan_c;

   modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
   modport sink   (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

FILE: design/badg_rsp_if.sv
// ---------------------------------------------------------------------------
// Cell result channel
// Valid/ready channel that carries one finished cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface badg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [badg_pkg::ROW_W-1:0]  cell_row;
   logic [badg_pkg::ROW_W-1:0]  cell_col;
   logic [badg_pkg::DARK_W-1:0] darkness;
   logic                        frame_end;

   modport source (output valid, output cell_row, output cell_col, output darkness,
                   output frame_end, input ready);
   modport sink   (input valid, input cell_row, input cell_col, input darkness,
                   input frame_end, output ready);
endinterface

FILE: design/badg_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module badg_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/badg_csr.sv
// ---------------------------------------------------------------------------
// Darkness grid registers
// APB register file with clamped geometry outputs and a write strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module badg_csr #(
   parameter int MAX_WIDTH = badg_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_CELL  = badg_pkg::MAX_CELL_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [badg_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [badg_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [badg_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic                                cfg_write,
   output logic [$clog2(MAX_CELL+1)-1:0]       cell_edge,
   output logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
   output logic [badg_pkg::H_W-1:0]            height_eff,
   output logic                                colour
);

   localparam int S_W = $clog2(MAX_CELL + 1);
   localparam int W_W = $clog2(MAX_WIDTH + 1);

   logic [badg_pkg::CS_REG_W-1:0]  cell_size_ff;
   logic [badg_pkg::DIM_REG_W-1:0] image_width_ff;
   logic [badg_pkg::DIM_REG_W-1:0] image_height_ff;
   logic                           colour_mode_ff;
   badg_pkg::badg_reg_type         reg_sel;

   assign reg_sel   = badg_pkg::badg_reg_type'(paddr[3:2]);
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff    <= badg_pkg::CELL_SIZE_RESET;
         image_width_ff  <= badg_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= badg_pkg::IMAGE_HEIGHT_RESET;
         colour_mode_ff  <= 1'b0;
      end else if (cfg_write) begin
         case (reg_sel)
            badg_pkg::REG_CELL_SIZE: begin
               cell_size_ff <= pwdata[badg_pkg::CS_REG_W-1:0];
            end
            badg_pkg::REG_IMAGE_WIDTH: begin
               image_width_ff <= pwdata[badg_pkg::DIM_REG_W-1:0];
            end
            badg_pkg::REG_IMAGE_HEIGHT: begin
               image_height_ff <= pwdata[badg_pkg::DIM_REG_W-1:0];
            end
            badg_pkg::REG_COLOUR_MODE: begin
               colour_mode_ff <= pwdata[0];
            end
            default: begin
               colour_mode_ff <= colour_mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         badg_pkg::REG_CELL_SIZE:    prdata = badg_pkg::CSR_DATA_W'(cell_size_ff);
         badg_pkg::REG_IMAGE_WIDTH:  prdata = badg_pkg::CSR_DATA_W'(image_width_ff);
         badg_pkg::REG_IMAGE_HEIGHT: prdata = badg_pkg::CSR_DATA_W'(image_height_ff);
         badg_pkg::REG_COLOUR_MODE:  prdata = badg_pkg::CSR_DATA_W'(colour_mode_ff);
         default:                    prdata = '0;
      endcase
   end

   // clamp geometry to the supported range
   always_comb begin
      if (cell_size_ff == '0) begin
         cell_edge = S_W'(1);
      end else if (32'(cell_size_ff) > 32'(MAX_CELL)) begin
         cell_edge = S_W'(MAX_CELL);
      end else begin
         cell_edge = S_W'(cell_size_ff);
      end

      if (image_width_ff == '0) begin
         width_eff = W_W'(1);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = W_W'(MAX_WIDTH);
      end else begin
         width_eff = W_W'(image_width_ff);
      end

      if (image_height_ff == '0) begin
         height_eff = badg_pkg::H_W'(1);
      end else if (32'(image_height_ff) > 32'(badg_pkg::HEIGHT_LIMIT)) begin
         height_eff = badg_pkg::H_W'(badg_pkg::HEIGHT_LIMIT);
      end else begin
         height_eff = badg_pkg::H_W'(image_height_ff);
      end
   end

   assign colour = colour_mode_ff;

endmodule

FILE: design/badg_div.sv
// ---------------------------------------------------------------------------
// Darkness divider
// Radix-2 restoring divider, one quotient bit per cycle, with result hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module badg_div #(
   parameter int SUM_W = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  badg_pkg::badg_div_ctrl_type   ctrl,
   input  logic [SUM_W-1:0]              numer,
   input  logic [SUM_W-1:0]              denom,
   input  badg_pkg::badg_tag_type        tag_in,
   output badg_pkg::badg_div_stat_type   stat,
   output logic [badg_pkg::DARK_W-1:0]   res_dark,
   output badg_pkg::badg_tag_type        res_tag
);

   localparam logic [badg_pkg::CNT_W-1:0] CNT_LAST = badg_pkg::CNT_W'(badg_pkg::DARK_W - 1);

   badg_pkg::badg_div_state_type state_ff, state_in;
   logic [SUM_W-1:0]             r_ff, r_in;
   logic [SUM_W-1:0]             d_ff, d_in;
   logic [badg_pkg::DARK_W-1:0]  q_ff, q_in;
   logic [badg_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   badg_pkg::badg_tag_type       tag_ff, tag_in_nx;
   logic [SUM_W:0]               trial;
   logic                         q_bit;
   logic [SUM_W-1:0]             r_step;

   always_comb begin
      trial  = (cnt_ff == '0) ? {1'b0, r_ff} : {r_ff, 1'b0};
      q_bit  = trial >= {1'b0, d_ff};
      r_step = q_bit ? SUM_W'(trial - {1'b0, d_ff}) : SUM_W'(trial);
   end

   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      d_in      = d_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      tag_in_nx = tag_ff;
      case (state_ff)
         badg_pkg::DIV_IDLE: begin
            if (ctrl.start) begin
               r_in      = numer;
               d_in      = denom;
               q_in      = '0;
               cnt_in    = '0;
               tag_in_nx = tag_in;
               state_in  = badg_pkg::DIV_RUN;
            end
         end
         badg_pkg::DIV_RUN: begin
            r_in   = r_step;
            q_in   = {q_ff[badg_pkg::DARK_W-2:0], q_bit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = badg_pkg::DIV_DONE;
            end
         end
         badg_pkg::DIV_DONE: begin
            if (ctrl.res_ready) begin
               state_in = badg_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = badg_pkg::DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= badg_pkg::DIV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      tag_ff <= tag_in_nx;
   end

   assign stat.idle      = state_ff == badg_pkg::DIV_IDLE;
   assign stat.res_valid = state_ff == badg_pkg::DIV_DONE;
   assign res_dark       = q_ff;
   assign res_tag        = tag_ff;

endmodule

FILE: design/block_average_darkness_grid_top.sv
// ---------------------------------------------------------------------------
// Darkness grid
// Box-filter downsampler: per-cell darkness of a raster-order image.
// ---------------------------------------------------------------------------
// Pixels enter on req_bus in raster order, one transfer per pixel. The image
// is cut into square cells of cell_size pixels; each finished cell leaves on
// rsp_bus with its row, column, darkness = 65536 * (1 - mean / full scale),
// floored, and frame_end on the last cell of the image. Pixels outside the
// whole-cell area are counted for position only.
// A pixel that does not finish a cell streams at one per clock while the
// divider is idle. A pixel that finishes a cell starts the serial divider;
// req_bus.ready drops and stays low until the divider is idle again.
// Cell sums live in a one-port-write, one-port-read RAM of MAX_WIDTH entries,
// read at transfer and written in the next cycle, with write-to-read forwarding.
// A result passes the sum stage, the divider and the output register to rsp_bus.
// Reset (synchronous) returns the registers to their defaults and the pixel
// position to the frame start; any register write also restarts the frame.
// The sum RAM needs no clearing: a cell's first pixel overwrites its entry.
// When rsp_bus stalls, the result is held in the output register and pixels
// keep flowing until a second result waits in the divider; req_bus.ready then
// stays low until rsp_bus takes the held result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_average_darkness_grid_top #(
   parameter int MAX_WIDTH = badg_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_CELL  = badg_pkg::MAX_CELL_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   badg_req_if.sink                        req_bus,
   badg_rsp_if.source                      rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [badg_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [badg_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [badg_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int S_W   = $clog2(MAX_CELL + 1);
   localparam int W_W   = $clog2(MAX_WIDTH + 1);
   localparam int CC_W  = $clog2(MAX_WIDTH);
   localparam int H_W   = badg_pkg::H_W;
   localparam int XS_W  = W_W + S_W + 1;
   localparam int YS_W  = H_W + S_W + 1;
   localparam int SUM_W = $clog2(MAX_CELL * MAX_CELL * 765 + 1);
   localparam int ROW_W = badg_pkg::ROW_W;

   logic             cfg_write;
   logic [S_W-1:0]   cell_edge;
   logic [W_W-1:0]   width_eff;
   logic [H_W-1:0]   height_eff;
   logic             colour;

   logic [W_W-1:0]   x_ff, x_in;
   logic [S_W-1:0]   ox_ff, ox_in;
   logic [W_W-1:0]   cbx_ff, cbx_in;
   logic [CC_W-1:0]  cc_ff, cc_in;
   logic [H_W-1:0]   y_ff, y_in;
   logic [S_W-1:0]   oy_ff, oy_in;
   logic [H_W-1:0]   cby_ff, cby_in;
   logic [ROW_W-1:0] cr_ff, cr_in;

   logic [XS_W-1:0]  x_end;
   logic [YS_W-1:0]  y_end;
   logic             in_x, in_y, last_x, last_y;
   logic             ox_last, oy_last;
   logic [badg_pkg::VAL_W-1:0] pix_val;
   logic             req_xfer;

   logic                       s1_valid_ff;
   logic                       s1_emit_ff;
   logic                       s1_first_ff;
   logic [CC_W-1:0]            s1_addr_ff;
   logic [badg_pkg::VAL_W-1:0] s1_val_ff;
   badg_pkg::badg_tag_type     s1_tag_ff;

   logic             fwd_valid_ff;
   logic [CC_W-1:0]  fwd_addr_ff;
   logic [SUM_W-1:0] fwd_data_ff;

   logic [SUM_W-1:0] rd_data;
   logic [SUM_W-1:0] sum_base;
   logic [SUM_W-1:0] sum_new;
   logic [2*S_W-1:0] edge_sq;
   logic [SUM_W-1:0] denom_grey;
   logic [SUM_W-1:0] denom;
   logic [SUM_W-1:0] numer;

   badg_pkg::badg_div_ctrl_type div_ctrl;
   badg_pkg::badg_div_stat_type div_stat;
   logic [badg_pkg::DARK_W-1:0] div_dark;
   badg_pkg::badg_tag_type      div_tag;

   logic                        out_valid_ff;
   logic [badg_pkg::DARK_W-1:0] out_dark_ff;
   badg_pkg::badg_tag_type      out_tag_ff;

   badg_csr #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_CELL  (MAX_CELL)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg_write  (cfg_write),
      .cell_edge  (cell_edge),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .colour     (colour)
   );

   // position and cell geometry
   always_comb begin
      x_end   = XS_W'(cbx_ff) + XS_W'(cell_edge);
      y_end   = YS_W'(cby_ff) + YS_W'(cell_edge);
      in_x    = x_end <= XS_W'(width_eff);
      in_y    = y_end <= YS_W'(height_eff);
      last_x  = (x_end + XS_W'(cell_edge)) > XS_W'(width_eff);
      last_y  = (y_end + YS_W'(cell_edge)) > YS_W'(height_eff);
      ox_last = ox_ff == (cell_edge - S_W'(1));
      oy_last = oy_ff == (cell_edge - S_W'(1));
      if (colour) begin
         pix_val = badg_pkg::VAL_W'(req_bus.chan_a) + badg_pkg::VAL_W'(req_bus.chan_b)
                 + badg_pkg::VAL_W'(req_bus.chan_c);
      end else begin
         pix_val = badg_pkg::VAL_W'(req_bus.chan_a);
      end
   end

   assign req_bus.ready = div_stat.idle && !(s1_valid_ff && s1_emit_ff);
   assign req_xfer      = req_bus.valid && req_bus.ready;

   always_comb begin
      x_in   = x_ff;
      ox_in  = ox_ff;
      cbx_in = cbx_ff;
      cc_in  = cc_ff;
      y_in   = y_ff;
      oy_in  = oy_ff;
      cby_in = cby_ff;
      cr_in  = cr_ff;
      if (cfg_write) begin
         x_in   = '0;
         ox_in  = '0;
         cbx_in = '0;
         cc_in  = '0;
         y_in   = '0;
         oy_in  = '0;
         cby_in = '0;
         cr_in  = '0;
      end else if (req_xfer) begin
         if (x_ff == width_eff - W_W'(1)) begin
            x_in   = '0;
            ox_in  = '0;
            cbx_in = '0;
            cc_in  = '0;
            if (y_ff == height_eff - H_W'(1)) begin
               y_in   = '0;
               oy_in  = '0;
               cby_in = '0;
               cr_in  = '0;
            end else begin
               y_in = y_ff + H_W'(1);
               if (oy_last) begin
                  oy_in  = '0;
                  cby_in = H_W'(y_end);
                  cr_in  = cr_ff + ROW_W'(1);
               end else begin
                  oy_in = oy_ff + S_W'(1);
               end
            end
         end else begin
            x_in = x_ff + W_W'(1);
            if (ox_last) begin
               ox_in  = '0;
               cbx_in = W_W'(x_end);
               cc_in  = cc_ff + CC_W'(1);
            end else begin
               ox_in = ox_ff + S_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         ox_ff        <= '0;
         cbx_ff       <= '0;
         cc_ff        <= '0;
         y_ff         <= '0;
         oy_ff        <= '0;
         cby_ff       <= '0;
         cr_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         x_ff         <= x_in;
         ox_ff        <= ox_in;
         cbx_ff       <= cbx_in;
         cc_ff        <= cc_in;
         y_ff         <= y_in;
         oy_ff        <= oy_in;
         cby_ff       <= cby_in;
         cr_ff        <= cr_in;
         s1_valid_ff  <= req_xfer && in_x && in_y;
         fwd_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_emit_ff         <= ox_last && oy_last;
      s1_first_ff        <= (ox_ff == '0) && (oy_ff == '0);
      s1_addr_ff         <= cc_ff;
      s1_val_ff          <= pix_val;
      s1_tag_ff.cell_row <= cr_ff;
      s1_tag_ff.cell_col <= ROW_W'(cc_ff);
      s1_tag_ff.frame_end <= last_x && last_y;
      fwd_addr_ff        <= s1_addr_ff;
      fwd_data_ff        <= sum_new;
   end

   badg_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_WIDTH)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (sum_new),
      .rd_en   (req_xfer),
      .rd_addr (cc_ff),
      .rd_data (rd_data)
   );

   // accumulate with forwarding of the write that lands on the read edge
   always_comb begin
      if (s1_first_ff) begin
         sum_base = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         sum_base = fwd_data_ff;
      end else begin
         sum_base = rd_data;
      end
      sum_new    = sum_base + SUM_W'(s1_val_ff);
      edge_sq    = cell_edge * cell_edge;
      denom_grey = (SUM_W'(edge_sq) << 8) - SUM_W'(edge_sq);
      denom      = colour ? (denom_grey + (denom_grey << 1)) : denom_grey;
      numer      = (sum_new >= denom) ? '0 : (denom - sum_new);
   end

   assign div_ctrl.start     = s1_valid_ff && s1_emit_ff;
   assign div_ctrl.res_ready = !out_valid_ff || rsp_bus.ready;

   badg_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .numer    (numer),
      .denom    (denom),
      .tag_in   (s1_tag_ff),
      .stat     (div_stat),
      .res_dark (div_dark),
      .res_tag  (div_tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (div_ctrl.res_ready) begin
         out_valid_ff <= div_stat.res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ctrl.res_ready && div_stat.res_valid) begin
         out_dark_ff <= div_dark;
         out_tag_ff  <= div_tag;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.cell_row  = out_tag_ff.cell_row;
   assign rsp_bus.cell_col  = out_tag_ff.cell_col;
   assign rsp_bus.darkness  = out_dark_ff;
   assign rsp_bus.frame_end = out_tag_ff.frame_end;

endmodule

FILE: design/badg_chk.sv
// ---------------------------------------------------------------------------
// Darkness grid port checker
// Watches the channel ports of the darkness grid top level over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_average_darkness_grid_top_assert.svh"

module badg_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [badg_pkg::DARK_W-1:0] rsp_darkness
);

   `BADG_ASSERT_NEXT(rsp_hold_valid, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BADG_ASSERT_NEXT(rsp_hold_dark, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_darkness))
   `BADG_ASSERT_SAME(rsp_dark_range, clock, reset, rsp_valid, rsp_darkness <= badg_pkg::DARK_FULL)
   `BADG_ASSERT_SAME(rsp_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind block_average_darkness_grid_top badg_chk u_badg_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_darkness (rsp_bus.darkness)
);

FILE: bench/block_average_darkness_grid_top_tb.sv
// ---------------------------------------------------------------------------
// Darkness grid testbench
// Streams raster-order pixels through the darkness grid under several cell,
// image and colour settings and checks every finished cell against an
// in-bench box-filter predictor. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_average_darkness_grid_top_tb;
   import badg_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_a;
      logic [CHAN_W-1:0] chan_b;
      logic [CHAN_W-1:0] chan_c;
   } pixel_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cell_row;
      logic [ROW_W-1:0]  cell_col;
      logic [DARK_W-1:0] darkness;
      logic              frame_end;
   } cell_type;

   logic                  clock;
   logic                  reset;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   badg_req_if req_bus ();
   badg_rsp_if rsp_bus ();

   block_average_darkness_grid_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   logic [CS_REG_W-1:0]  cfg_cell   = CELL_SIZE_RESET;
   logic [DIM_REG_W-1:0] cfg_width  = IMAGE_WIDTH_RESET;
   logic [DIM_REG_W-1:0] cfg_height = IMAGE_HEIGHT_RESET;
   logic                 cfg_colour = 1'b0;
   int unsigned          pos_x = 0;
   int unsigned          pos_y = 0;
   int unsigned          col_sum [MAX_WIDTH_DEFAULT];

   pixel_type pixels_to_send [$];
   cell_type  finished_cells [$];
   int        pushed_count   = 0;
   int        accepted_count = 0;
   int        errors         = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // accumulate one accepted pixel and queue the cell it finishes, if any
   function automatic void sum_pixel(pixel_type px);
      int unsigned     s, w, h, cols, rows, cc, cr, ox, oy, val;
      longint unsigned full, dark;
      cell_type        c;
      s    = clamp_dim(cfg_cell, 1, MAX_CELL_DEFAULT);
      w    = clamp_dim(cfg_width, 1, MAX_WIDTH_DEFAULT);
      h    = clamp_dim(cfg_height, 1, HEIGHT_LIMIT);
      cols = w / s;
      rows = h / s;
      cc   = pos_x / s;
      cr   = pos_y / s;
      ox   = pos_x % s;
      oy   = pos_y % s;
      val  = int'(px.chan_a);
      if (cfg_colour)
         val += int'(px.chan_b) + int'(px.chan_c);
      if (cc < cols && cr < rows) begin
         if (ox == 0 && oy == 0)
            col_sum[cc] = val;
         else
            col_sum[cc] += val;
         if (ox == s - 1 && oy == s - 1) begin
            full = longint'(s) * s * 255 * (cfg_colour ? 3 : 1);
            dark = (64'd65536 * (full - col_sum[cc])) / full;
            c.cell_row  = ROW_W'(cr);
            c.cell_col  = ROW_W'(cc);
            c.darkness  = DARK_W'(dark);
            c.frame_end = (cr == rows - 1 && cc == cols - 1);
            finished_cells.push_back(c);
         end
      end
      pos_x++;
      if (pos_x >= w) begin
         pos_x = 0;
         pos_y++;
         if (pos_y >= h)
            pos_y = 0;
      end
   endfunction

   // pixel driver: bursts of random length with random gaps
   pixel_type drive_px;
   int        burst_left = 0;
   int        gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.chan_a <= '0;
         req_bus.chan_b <= '0;
         req_bus.chan_c <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            sum_pixel(drive_px);
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pixels_to_send.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else begin
               drive_px = pixels_to_send.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.chan_a <= drive_px.chan_a;
               req_bus.chan_b <= drive_px.chan_b;
               req_bus.chan_c <= drive_px.chan_c;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(0, 20);
                  case ($urandom_range(0, 3))
                     0: gap_left = 0;
                     1: gap_left = $urandom_range(1, 3);
                     2: gap_left = $urandom_range(4, 12);
                     default: gap_left = $urandom_range(13, 30);
                  endcase
               end
            end
         end
      end
   end

   // result monitor with its own stall pattern
   int       ready_run   = 0;
   int       ready_stall = 0;
   cell_type want;

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (finished_cells.size() == 0) begin
               errors++;
               $display("%0t: unexpected cell, expected none, actual row %0d col %0d dark %0d",
                        $time, rsp_bus.cell_row, rsp_bus.cell_col, rsp_bus.darkness);
            end else begin
               want = finished_cells.pop_front();
               check_field("cell_row", want.cell_row, rsp_bus.cell_row);
               check_field("cell_col", want.cell_col, rsp_bus.cell_col);
               check_field("darkness", want.darkness, rsp_bus.darkness);
               check_field("frame_end", want.frame_end, rsp_bus.frame_end);
            end
         end
         if (ready_stall > 0) begin
            ready_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (ready_run > 0) begin
               ready_run--;
            end else if ($urandom_range(0, 9) == 0) begin
               ready_run = $urandom_range(100, 300);
            end else begin
               ready_run   = $urandom_range(0, 15);
               ready_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end
         end
      end
   end

   task automatic queue_pixel(input pixel_type px);
      pixels_to_send.push_back(px);
      pushed_count++;
   endtask

   task automatic wait_drained();
      while (accepted_count != pushed_count || finished_cells.size() != 0)
         @(posedge clock);
   endtask

   // drain, then let the divider finish any cell still in flight
   task automatic settle();
      wait_drained();
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input badg_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_CELL_SIZE:    cfg_cell   = value[CS_REG_W-1:0];
         REG_IMAGE_WIDTH:  cfg_width  = value[DIM_REG_W-1:0];
         REG_IMAGE_HEIGHT: cfg_height = value[DIM_REG_W-1:0];
         REG_COLOUR_MODE:  cfg_colour = value[0];
      endcase
      pos_x = 0;
      pos_y = 0;
   endtask

   task automatic configure(input int cell_sz, input int width, input int height,
                            input int colour, input bit partial);
      settle();
      if (!partial || $urandom_range(0, 3) != 0) csr_write(REG_CELL_SIZE, cell_sz);
      if (!partial || $urandom_range(0, 3) != 0) csr_write(REG_IMAGE_WIDTH, width);
      if (!partial || $urandom_range(0, 3) != 0) csr_write(REG_IMAGE_HEIGHT, height);
      if (!partial || $urandom_range(0, 3) != 0) csr_write(REG_COLOUR_MODE, colour);
   endtask

   // queue n pixels; sometimes hold the stream until every cell has come back
   task automatic send_pixels(input int n);
      int        kind;
      int        split;
      pixel_type px;
      kind  = $urandom_range(0, 7);
      split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
      for (int i = 0; i < n; i++) begin
         if (i == split)
            wait_drained();
         case (kind)
            0: px = '{8'd255, 8'd255, 8'd255};
            1: px = '{8'd0, 8'd0, 8'd0};
            default: px = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255))};
         endcase
         queue_pixel(px);
      end
   endtask

   int s, w, h, cols_n, rows_n, n;
   int random_pixels;

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.chan_a = '0;
      req_bus.chan_b = '0;
      req_bus.chan_c = '0;
      rsp_bus.ready  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default image size and grey mode, one-pixel cells
      csr_write(REG_CELL_SIZE, 1);
      queue_pixel('{8'd0, 8'd255, 8'd255});
      queue_pixel('{8'd255, 8'd0, 8'd0});
      queue_pixel('{8'd128, 8'd7, 8'd200});
      queue_pixel('{8'd1, 8'd254, 8'd0});

      // colour mode, odd width and height leave a strip outside the grid
      configure(2, 5, 3, 1, 1'b0);
      for (int y = 0; y < 3; y++) begin
         for (int x = 0; x < 5; x++) begin
            if (y == 1 && x == 2)
               wait_drained();
            if (y < 2 && x < 2)
               queue_pixel('{8'd255, 8'd255, 8'd255});
            else if (y < 2 && x < 4)
               queue_pixel('{8'd0, 8'd0, 8'd0});
            else
               queue_pixel('{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255))});
         end
      end

      // image narrower than a cell
      configure(4, 3, 10, 0, 1'b0);
      send_pixels(3);

      // zero sizes clamp to one
      configure(0, 0, 0, 1, 1'b0);
      send_pixels(6);
      // oversized cell clamps to the largest
      configure(17, 16, 16, 1, 1'b0);
      send_pixels(256);
      configure(31, 20, 18, 1, 1'b0);
      send_pixels(40);
      // oversized width and height clamp to the limits
      configure(1, 2047, 2047, 0, 1'b0);
      send_pixels(40);
      configure(2, 2, HEIGHT_LIMIT, 1, 1'b0);
      send_pixels(12);
      configure(1, 1, 1, 0, 1'b0);
      send_pixels(12);

      random_pixels = 0;
      while (random_pixels < 450) begin
         s = $urandom_range(1, 4);
         if ($urandom_range(0, 7) == 0)
            s = $urandom_range(5, MAX_CELL_DEFAULT);
         cols_n = (s > 4) ? 1 : $urandom_range(1, 4);
         rows_n = (s > 4) ? 1 : $urandom_range(1, 3);
         w = s * cols_n + $urandom_range(0, s - 1);
         h = s * rows_n + $urandom_range(0, s - 1);
         if ($urandom_range(0, 15) == 0)
            w = $urandom_range(1, s);
         configure(s, w, h, $urandom_range(0, 1), $urandom_range(0, 3) == 0);
         w = clamp_dim(cfg_width, 1, MAX_WIDTH_DEFAULT);
         h = clamp_dim(cfg_height, 1, HEIGHT_LIMIT);
         n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
         if (n > 200)
            n = 200;
         send_pixels(n);
         random_pixels += n;
      end

      settle();
      if (errors == 0 && finished_cells.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
